>>> design/assert_macros.svh
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define AST_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define AST_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the following cycle.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/cdq_pkg.sv
// Types, codes and sizes shared by the deque design.
package cdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int OP_W = 3;
    localparam int VAL_W = 32;
    localparam int ST_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [OP_W-1:0] op_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [ST_W-1:0] status_t;
    typedef logic [IDX_W-1:0] slot_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic  shift_up;
        logic  shift_down;
        logic  load_rear;
        slot_t rear_slot;
        slot_t tail_slot;
    } cell_cmd_t;

    // Result control handed from the controller to the output stage.
    typedef struct packed {
        status_t status;
        logic    rd_front;
        logic    rd_rear;
        logic    full;
        logic    empty;
    } res_ctl_t;

endpackage

>>> design/cdq_channels.sv
// Handshake channel interfaces for operations and results.
interface cdq_op_if;
    import cdq_pkg::*;

    logic valid;
    logic ready;
    op_t  operation;
    val_t value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface cdq_res_if;
    import cdq_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    val_t    data;
    logic    full_res;
    logic    empty_res;

    modport source (output valid, output status, output data, output full_res,
                    output empty_res, input ready);
    modport sink (input valid, input status, input data, input full_res,
                  input empty_res, output ready);
endinterface

>>> design/cdq_cell.sv
// One storage cell of the deque row.
module cdq_cell (
    input  logic              clk,
    input  cdq_pkg::cell_cmd_t cmd,
    input  cdq_pkg::slot_t    slot,
    input  cdq_pkg::val_t     push_value,
    input  cdq_pkg::val_t     left_value,
    input  cdq_pkg::val_t     right_value,
    output cdq_pkg::val_t     value,
    output cdq_pkg::val_t     tail_tap
);
    import cdq_pkg::*;

    val_t value_reg;
    val_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.shift_up)
        begin
            value_next = left_value;
        end
        else if (cmd.shift_down)
        begin
            value_next = right_value;
        end
        else if (cmd.load_rear && (slot == cmd.rear_slot))
        begin
            value_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    // Drive onto the shared OR bus only from the cell at tail_slot, the last occupied cell when not empty.
    assign tail_tap = (slot == cmd.tail_slot) ? value_reg : '0;
endmodule

>>> design/cdq_ctrl.sv
// Fill count, capacity register and operation decode for the deque.
module cdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_data,
    input  logic                accept,
    input  cdq_pkg::op_t        operation,
    output cdq_pkg::cell_cmd_t  cmd,
    output cdq_pkg::res_ctl_t   res_ctl,
    output cdq_pkg::cnt_t       fill
);
    import cdq_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    cnt_t             count_reg;
    cnt_t             count_next;
    cnt_t             cap_eff;
    logic             is_full;
    logic             is_empty;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(cap_reg) > DEPTH)
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign is_full  = (count_reg == cap_eff);
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        count_next        = count_reg;
        cmd.shift_up      = 1'b0;
        cmd.shift_down    = 1'b0;
        cmd.load_rear     = 1'b0;
        cmd.rear_slot     = count_reg[IDX_W-1:0];
        cmd.tail_slot     = IDX_W'(count_reg - CNT_W'(1));
        res_ctl.status    = ST_OK;
        res_ctl.rd_front  = 1'b0;
        res_ctl.rd_rear   = 1'b0;
        unique case (operation) inside
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    res_ctl.status = ST_FULL;
                end
                else
                begin
                    count_next     = count_reg + CNT_W'(1);
                    cmd.shift_up   = accept && (operation == OP_PUSH_FRONT);
                    cmd.load_rear  = accept && (operation == OP_PUSH_REAR);
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (is_empty)
                begin
                    res_ctl.status = ST_EMPTY;
                end
                else
                begin
                    res_ctl.rd_front = (operation == OP_POP_FRONT) ||
                                       (operation == OP_PEEK_FRONT);
                    res_ctl.rd_rear  = !res_ctl.rd_front;
                    if ((operation == OP_POP_FRONT) || (operation == OP_POP_REAR))
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        cmd.shift_down = accept && (operation == OP_POP_FRONT);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        res_ctl.full  = (count_next == cap_eff);
        res_ctl.empty = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg   <= cfg_data;
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    assign fill = count_reg;
endmodule

>>> design/circular_deque_unit.sv
// Top level of the double-ended queue: cell row, controller and result register.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------
//  op       | in  | valid / ready     | operation, value
//  res      | out | valid / ready     | status, data, full_res, empty_res
//  cfg      | in  | cfg_we (no wait)  | cfg_data (capacity)
//
// One operation per cycle unless stalled: the controller decodes a beat and the
// cell row shifts or loads in the same edge; the result lands in one output
// register. A new beat is taken while that register is empty or being drained.
// Reset empties the deque and sets capacity to 16; no clearing pass is needed.
// A capacity write empties the deque.
`include "assert_macros.svh"

module circular_deque_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_data,
    cdq_op_if.sink                    op,
    cdq_res_if.source                 res
);
    import cdq_pkg::*;

    cell_cmd_t cmd;
    res_ctl_t  res_ctl;
    cnt_t      fill;
    logic      accept;
    val_t      cell_value [DEPTH];
    val_t      tail_tap [DEPTH];
    val_t      rear_value;
    val_t      data_next;

    logic      res_valid_reg;
    status_t   status_reg;
    val_t      data_reg;
    logic      full_reg;
    logic      empty_reg;

    assign op.ready = !res_valid_reg || res.ready;
    assign accept   = op.valid && op.ready;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .operation (op.operation),
        .cmd       (cmd),
        .res_ctl   (res_ctl),
        .fill      (fill)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        val_t left_value;
        val_t right_value;

        if (i == 0)
        begin : g_first
            assign left_value = op.value;
        end
        else
        begin : g_mid
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        cdq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .slot        (IDX_W'(i)),
            .push_value  (op.value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .tail_tap    (tail_tap[i])
        );
    end

    always_comb
    begin
        rear_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_value = rear_value | tail_tap[i];
        end
    end

    always_comb
    begin
        if (res_ctl.rd_front)
        begin
            data_next = cell_value[0];
        end
        else if (res_ctl.rd_rear)
        begin
            data_next = rear_value;
        end
        else if (res_ctl.status == ST_EMPTY)
        begin
            data_next = '1;
        end
        else
        begin
            data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Capture the result with the beat that produced it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= res_ctl.status;
            data_reg   <= data_next;
            full_reg   <= res_ctl.full;
            empty_reg  <= res_ctl.empty;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.status    = status_reg;
    assign res.data      = data_reg;
    assign res.full_res  = full_reg;
    assign res.empty_res = empty_reg;

    `AST_ALWAYS(a_fill_in_range, int'(fill) <= DEPTH)
    `AST_NEXT(a_cfg_empties, cfg_we, fill == '0)
    `AST_IMPLY(a_full_empty_excl, res.valid, !(res.full_res && res.empty_res))
    `AST_IMPLY(a_empty_data, res.valid && (res.status == ST_EMPTY), res.data == '1)
endmodule

>>> test/tb_circular_deque_unit.sv
// Self-checking testbench for the circular deque unit with a built-in deque predictor.
`timescale 1ns / 100ps

module tb_circular_deque_unit;
    import cdq_pkg::*;

    localparam op_t OP_NOP_SIX   = 3'd6;
    localparam op_t OP_NOP_SEVEN = 3'd7;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 68;

    typedef struct packed {
        status_t status;
        val_t    data;
        logic    full;
        logic    empty;
    } deque_result_t;

    class deque_tracker;
        val_t            ring [DEPTH];
        int unsigned     head;
        int unsigned     tail;
        int unsigned     cap_reg;
        bit              vacant;
        deque_result_t   awaited [$];
        int              errors;

        function new();
            cap_reg = CAP_RESET;
            head = 0;
            tail = 0;
            vacant = 1;
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            cap_reg = c;
            head = 0;
            tail = 0;
            vacant = 1;
        endfunction

        function int unsigned span();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > DEPTH)
                return DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_up(int unsigned i, int unsigned c);
            return (i + 1 >= c) ? 0 : i + 1;
        endfunction

        function int unsigned step_down(int unsigned i, int unsigned c);
            return (i == 0 || i >= c) ? c - 1 : i - 1;
        endfunction

        function bit is_full(int unsigned c);
            return !vacant && step_up(tail, c) == head;
        endfunction

        function void take_op(op_t o, val_t v);
            int unsigned   c;
            deque_result_t r;
            bit            front;
            c = span();
            r.status = ST_OK;
            r.data = '0;
            case (o)
                OP_PUSH_FRONT, OP_PUSH_REAR:
                begin
                    if (is_full(c))
                        r.status = ST_FULL;
                    else if (vacant)
                    begin
                        head = 0;
                        tail = 0;
                        vacant = 0;
                        ring[0] = v;
                    end
                    else if (o == OP_PUSH_FRONT)
                    begin
                        head = step_down(head, c);
                        ring[head] = v;
                    end
                    else
                    begin
                        tail = step_up(tail, c);
                        ring[tail] = v;
                    end
                end
                OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
                begin
                    if (vacant)
                    begin
                        r.status = ST_EMPTY;
                        r.data = -1;
                    end
                    else
                    begin
                        front = (o == OP_POP_FRONT || o == OP_PEEK_FRONT);
                        r.data = ring[front ? head : tail];
                        if (o == OP_POP_FRONT || o == OP_POP_REAR)
                        begin
                            if (head == tail)
                            begin
                                head = 0;
                                tail = 0;
                                vacant = 1;
                            end
                            else if (front)
                                head = step_up(head, c);
                            else
                                tail = step_down(tail, c);
                        end
                    end
                end
                default: ;
            endcase
            r.full = is_full(c);
            r.empty = vacant;
            awaited.push_back(r);
        endfunction

        function void check_result(status_t s, val_t d, logic f, logic e);
            deque_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result beat with no operation pending");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (s !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, s);
                errors++;
            end
            if (d !== want.data)
            begin
                $error("data: expected %0d, got %0d", want.data, d);
                errors++;
            end
            if (f !== want.full)
            begin
                $error("full_res: expected %0b, got %0b", want.full, f);
                errors++;
            end
            if (e !== want.empty)
            begin
                $error("empty_res: expected %0b, got %0b", want.empty, e);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               quiet_cycles;

    cdq_op_if  op_ch ();
    cdq_res_if res_ch ();

    deque_tracker tracker = new();

    circular_deque_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .op       (op_ch),
        .res      (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels at the falling edge, where everything has settled.
    always @(negedge clk)
    begin
        if (rst_n && op_ch.valid && op_ch.ready)
            tracker.take_op(op_ch.operation, op_ch.value);
        if (rst_n && res_ch.valid && res_ch.ready)
            tracker.check_result(res_ch.status, res_ch.data, res_ch.full_res,
                                 res_ch.empty_res);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic send_op(input op_t o, input val_t v);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            @(posedge clk);
        end
        op_ch.valid <= 1'b1;
        op_ch.operation <= o;
        op_ch.value <= v;
        do
        begin
            @(negedge clk);
            took = op_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Drop valid and hold until every outstanding beat has come back.
    task automatic drain();
        op_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        cfg_we <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_capacity(c);
    endtask

    function automatic val_t pick_value();
        case ($urandom_range(15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_op(int push_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom_range(1) ? OP_NOP_SEVEN : OP_NOP_SIX;
        if (r < 3 + push_pct)
            return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        if ($urandom_range(9) < 7)
            return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
        return $urandom_range(1) ? OP_PEEK_REAR : OP_PEEK_FRONT;
    endfunction

    // Bursts lean toward filling, toward draining or stay mixed so both ends get hit.
    task automatic run_phase(input int items);
        int left;
        int burst;
        int push_pct;
        left = items;
        while (left > 0)
        begin
            burst = $urandom_range(24, 4);
            case ($urandom_range(2))
                0: push_pct = 15;
                1: push_pct = 47;
                default: push_pct = 82;
            endcase
            while (burst > 0 && left > 0)
            begin
                send_op(pick_op(push_pct), pick_value());
                burst--;
                left--;
            end
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps [PHASE_COUNT];
        caps = '{5'd16, 5'd1, 5'd2, 5'd5, 5'd0, 5'd31, 5'd3, 5'd8, 5'd17, 5'd15,
                 5'd10, 5'd4};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        op_ch.valid = 1'b0;
        op_ch.operation = OP_PUSH_FRONT;
        op_ch.value = '0;
        res_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque at reset capacity, then a short fill and drain.
        send_op(OP_POP_FRONT, 32'sd5);
        send_op(OP_POP_REAR, 32'sd5);
        send_op(OP_PEEK_FRONT, 32'sd5);
        send_op(OP_PEEK_REAR, 32'sd5);
        send_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(OP_PUSH_REAR, 32'sh8000_0000);
        send_op(OP_PUSH_FRONT, -1);
        send_op(OP_PUSH_REAR, '0);
        send_op(OP_PEEK_FRONT, '0);
        send_op(OP_PEEK_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '0);
        send_op(OP_NOP_SIX, 32'sh1234_5678);
        send_op(OP_NOP_SEVEN, -1);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        drain();

        // Single-entry ring: full right after the first push.
        write_capacity(5'd1);
        send_op(OP_PUSH_REAR, 32'sh1234_5678);
        send_op(OP_PUSH_FRONT, 32'sh0BAD_F00D);
        send_op(OP_PUSH_REAR, 32'sh0BAD_F00D);
        send_op(OP_PEEK_REAR, '0);
        send_op(OP_POP_FRONT, '0);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 53;
                end
                default:
                begin
                    send_idle_pct = 16;
                    recv_stall_pct = 16;
                end
            endcase
            write_capacity(caps[p]);
            run_phase(PHASE_ITEMS);
            drain();
        end

        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        if (tracker.awaited.size() != 0)
            $error("%0d expected results never arrived", tracker.awaited.size());
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/cdq_pkg.sv
design/cdq_channels.sv
design/cdq_cell.sv
design/cdq_ctrl.sv
design/circular_deque_unit.sv
test/tb_circular_deque_unit.sv
